[rtl/aesctr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 CTR crypt unit package
// Shared widths, the sequencer state type, the S-box and the GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aesctr_pkg;

	localparam int WORD_W   = 64;
	localparam int BLOCK_W  = 128;
	localparam int BYTES    = 16;
	localparam int CNT_W    = 5;
	localparam int NUM_RND  = 10;
	localparam int NUM_RK   = NUM_RND + 1;
	localparam int RK_AW    = $clog2(NUM_RK);
	localparam int RND_W    = $clog2(NUM_RND + 1);
	localparam int CFG_AW   = 2;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] CFG_KEY_HIGH   = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_KEY_LOW    = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_NONCE_HIGH = 2'd2;
	localparam logic [CFG_AW-1:0] CFG_NONCE_LOW  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_LOAD,
		ST_ROUND,
		ST_FINISH
	} state_t;

	// One write into the round key store.
	typedef struct packed {
		logic               en;
		logic [RK_AW-1:0]   addr;
		logic [BLOCK_W-1:0] data;
	} rk_wr_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
		8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
		8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
		8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
		8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
		8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
		8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
		8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
		8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
		8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
		8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
		8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
		8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
		8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
		8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
		8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
		8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] sub_byte(input logic [7:0] b);
		return SBOX[b];
	endfunction

	// Multiply by x in GF(2^8) with the AES polynomial.
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Round constant used to derive round key idx+1.
	function automatic logic [7:0] rcon(input logic [RK_AW-1:0] idx);
		logic [7:0] r;
		unique case (idx)
			4'd0:    r = 8'h01;
			4'd1:    r = 8'h02;
			4'd2:    r = 8'h04;
			4'd3:    r = 8'h08;
			4'd4:    r = 8'h10;
			4'd5:    r = 8'h20;
			4'd6:    r = 8'h40;
			4'd7:    r = 8'h80;
			4'd8:    r = 8'h1b;
			4'd9:    r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/aesctr_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Input block channel
// Carries one 16-byte data word with its length and first-block flag.
// ----------------------------------------------------------------------------
interface aesctr_in_if
	import aesctr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               first_block;
	logic [WORD_W-1:0]  data_high;
	logic [WORD_W-1:0]  data_low;
	logic [CNT_W-1:0]   valid_bytes;

	modport source (output valid, first_block, data_high, data_low, valid_bytes,
		input ready);
	modport sink (input valid, first_block, data_high, data_low, valid_bytes,
		output ready);
endinterface
`default_nettype wire

[rtl/aesctr_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Result block channel
// Carries one crypted 16-byte word and its count of valid bytes.
// ----------------------------------------------------------------------------
interface aesctr_out_if
	import aesctr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [WORD_W-1:0]  out_high;
	logic [WORD_W-1:0]  out_low;
	logic [CNT_W-1:0]   out_count;

	modport source (output valid, out_high, out_low, out_count, input ready);
	modport sink (input valid, out_high, out_low, out_count, output ready);
endinterface
`default_nettype wire

[rtl/aesctr_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and a 64-bit write word.
// ----------------------------------------------------------------------------
interface aesctr_cfg_if
	import aesctr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CFG_AW-1:0]  index;
	logic [WORD_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/aes128_ctr_crypt_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 counter-mode crypt unit
// XORs each 16-byte input word with the AES-128 encryption of a running
// counter. The key and the starting counter come from four config registers.
// ----------------------------------------------------------------------------
// Usage:
// Write key_high, key_low, nonce_high and nonce_low on the cfg channel
// (indexes 0 to 3) while the unit is idle; cfg is always ready. A word
// with first_block set expands the key into the round key store and loads
// the counter from the nonce before it is crypted; the first word after
// reset must carry first_block. The counter advances once per word.
// A word passes from acceptance through ST_EXPAND (only when first_block
// is set), ST_LOAD, ST_ROUND and ST_FINISH to a valid result. One shared
// round unit runs the ten rounds, one per cycle, after the initial key
// addition, fed by the registered read of the round key store; key
// expansion writes one round key per cycle. The unit takes the next word
// as soon as the result sits in the output register, not before.
// If the receiver stalls, the result holds there and a following
// word runs its rounds but waits before its result until the slot frees.
// Reset clears the config registers, the counter and all control state.
// ----------------------------------------------------------------------------
module aes128_ctr_crypt_unit
	import aesctr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	aesctr_in_if.sink    item,
	aesctr_out_if.source result,
	aesctr_cfg_if.sink   cfg
);

	state_t st_q, st_d;

	logic [WORD_W-1:0]  key_high_q, key_low_q, nonce_high_q, nonce_low_q;
	logic [BLOCK_W-1:0] ctr_q;
	logic [BLOCK_W-1:0] data_q;
	logic [CNT_W-1:0]   vb_q;
	logic [RND_W-1:0]   rnd_q;
	logic [BLOCK_W-1:0] aes_q;

	logic               out_vld_q;
	logic [WORD_W-1:0]  out_high_q, out_low_q;
	logic [CNT_W-1:0]   out_count_q;

	logic               accept;
	logic               ke_start, ke_done;
	rk_wr_t             rk_wr;
	logic               rd_en;
	logic [RK_AW-1:0]   rd_addr;
	logic [BLOCK_W-1:0] rk_rd;
	logic [BLOCK_W-1:0] round_out;
	logic               fin_go;
	logic               in_ready;

	logic [CNT_W-1:0]   vb_sat;
	logic [BLOCK_W-1:0] ks_mask;

	assign accept = item.valid && in_ready;

	// Next-state logic.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					st_d = item.first_block ? ST_EXPAND : ST_LOAD;
				end
			end
			ST_EXPAND: begin
				if (ke_done) begin
					st_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				st_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == RND_W'(NUM_RND)) begin
					st_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (fin_go) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready = 1'b0;
		ke_start = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		fin_go   = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ke_start = item.valid && item.first_block;
			end
			ST_EXPAND: begin
			end
			ST_LOAD: begin
				rd_en = 1'b1;
			end
			ST_ROUND: begin
				// The key for the next round is fetched while the current round runs.
				rd_en   = (rnd_q != RND_W'(NUM_RND));
				rd_addr = RK_AW'(rnd_q) + RK_AW'(1);
			end
			ST_FINISH: begin
				fin_go = !out_vld_q || result.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q   <= '0;
			key_low_q    <= '0;
			nonce_high_q <= '0;
			nonce_low_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_KEY_HIGH:   key_high_q   <= cfg.data;
				CFG_KEY_LOW:    key_low_q    <= cfg.data;
				CFG_NONCE_HIGH: nonce_high_q <= cfg.data;
				CFG_NONCE_LOW:  nonce_low_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// Counter: reloaded on a first block, stepped once each word is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (accept && item.first_block) begin
			ctr_q <= {nonce_high_q, nonce_low_q};
		end else if (st_q == ST_FINISH && fin_go) begin
			ctr_q <= ctr_q + BLOCK_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (accept) begin
			rnd_q <= '0;
		end else if (st_q == ST_ROUND) begin
			rnd_q <= rnd_q + RND_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= {item.data_high, item.data_low};
			vb_q   <= item.valid_bytes;
		end
		if (st_q == ST_ROUND) begin
			aes_q <= (rnd_q == '0) ? (ctr_q ^ rk_rd) : round_out;
		end
	end

	aesctr_keyexp u_keyexp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ke_start),
		.key    ({key_high_q, key_low_q}),
		.rk_wr  (rk_wr),
		.done   (ke_done)
	);

	aesctr_ram #(
		.WIDTH (BLOCK_W),
		.DEPTH (NUM_RK)
	) u_rk_store (
		.clk   (clk),
		.we    (rk_wr.en),
		.waddr (rk_wr.addr),
		.wdata (rk_wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rk_rd)
	);

	aesctr_round u_round (
		.state_in  (aes_q),
		.round_key (rk_rd),
		.last      (rnd_q == RND_W'(NUM_RND)),
		.state_out (round_out)
	);

	// Lengths above sixteen saturate; bytes past the length read as zero.
	always_comb begin
		vb_sat = (vb_q > CNT_W'(BYTES)) ? CNT_W'(BYTES) : vb_q;
		for (int k = 0; k < BYTES; k++) begin
			ks_mask[BLOCK_W-1-8*k -: 8] = (CNT_W'(k) < vb_sat) ? 8'hff : 8'h00;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (st_q == ST_FINISH && fin_go) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_FINISH && fin_go) begin
			{out_high_q, out_low_q} <= (data_q ^ aes_q) & ks_mask;
			out_count_q             <= vb_sat;
		end
	end

	assign item.ready       = in_ready;
	assign result.valid     = out_vld_q;
	assign result.out_high  = out_high_q;
	assign result.out_low   = out_low_q;
	assign result.out_count = out_count_q;

`ifndef SYNTH
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROUND) |-> (rnd_q <= RND_W'(NUM_RND)))
		else $error("round counter ran past the last round");

	a_expand_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EXPAND) |-> rk_wr.en)
		else $error("expansion state without key expansion running");

	a_no_expand_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LOAD || st_q == ST_ROUND) |-> !rk_wr.en)
		else $error("round key store written while rounds are running");

	a_round_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROUND && rnd_q == '0) |-> ($past(st_q) == ST_LOAD))
		else $error("rounds started without a key fetch");

	a_finish_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FINISH && out_vld_q && !result.ready) |=> (st_q == ST_FINISH))
		else $error("result dropped while output register was full");
`endif

endmodule
`default_nettype wire

[rtl/aesctr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module aesctr_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 11
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/aesctr_keyexp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Derives one round key per cycle from the previous one and writes it out.
// ----------------------------------------------------------------------------
module aesctr_keyexp
	import aesctr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [BLOCK_W-1:0] key,
	output rk_wr_t                  rk_wr,
	output logic                    done
);

	logic               busy_q;
	logic [RK_AW-1:0]   idx_q;
	logic [BLOCK_W-1:0] rk_q;
	logic [BLOCK_W-1:0] rk_next;

	always_comb begin
		logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
		w0 = rk_q[127:96];
		w1 = rk_q[95:64];
		w2 = rk_q[63:32];
		w3 = rk_q[31:0];
		// RotWord then SubWord on the last word, with the round constant.
		t  = {sub_byte(w3[23:16]) ^ rcon(idx_q), sub_byte(w3[15:8]),
			sub_byte(w3[7:0]), sub_byte(w3[31:24])};
		n0 = w0 ^ t;
		n1 = w1 ^ n0;
		n2 = w2 ^ n1;
		n3 = w3 ^ n2;
		rk_next = {n0, n1, n2, n3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (idx_q == RK_AW'(NUM_RND)) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + RK_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rk_q <= key;
		end else if (busy_q) begin
			rk_q <= rk_next;
		end
	end

	assign rk_wr.en   = busy_q;
	assign rk_wr.addr = idx_q;
	assign rk_wr.data = rk_q;
	assign done       = busy_q && (idx_q == RK_AW'(NUM_RND));

endmodule
`default_nettype wire

[rtl/aesctr_round.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// AES round unit
// SubBytes, ShiftRows, optional MixColumns and AddRoundKey on one state.
// ----------------------------------------------------------------------------
module aesctr_round
	import aesctr_pkg::*;
(
	input  wire logic [BLOCK_W-1:0] state_in,
	input  wire logic [BLOCK_W-1:0] round_key,
	input  wire logic               last,
	output logic      [BLOCK_W-1:0] state_out
);

	logic [7:0] s [BYTES];
	logic [7:0] t [BYTES];
	logic [7:0] m [BYTES];

	// Byte k of the state sits at bits 127-8k down; columns are four bytes.
	always_comb begin
		for (int k = 0; k < BYTES; k++) begin
			s[k] = state_in[BLOCK_W-1-8*k -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[r+4*c] = sub_byte(s[r + 4*((c + r) & 3)]);
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, all;
			a0 = t[4*c];
			a1 = t[4*c+1];
			a2 = t[4*c+2];
			a3 = t[4*c+3];
			all = a0 ^ a1 ^ a2 ^ a3;
			m[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
			m[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
			m[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
			m[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		for (int k = 0; k < BYTES; k++) begin
			state_out[BLOCK_W-1-8*k -: 8] = (last ? t[k] : m[k])
				^ round_key[BLOCK_W-1-8*k -: 8];
		end
	end

endmodule
`default_nettype wire

[dv/tb_aes128_ctr_crypt_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 CTR crypt unit testbench
// Sends data words through the unit while both sides idle in random bursts.
// Each accepted word is predicted by a local AES-128 counter-mode model and
// compared field by field with the result words in order. Key and nonce
// are reprogrammed between phases, including the all-zero, all-one and
// counter-wrap settings.
// ----------------------------------------------------------------------------
module tb_aes128_ctr_crypt_unit;
	import aesctr_pkg::*;

	typedef struct packed {
		logic              first_block;
		logic [WORD_W-1:0] data_high;
		logic [WORD_W-1:0] data_low;
		logic [CNT_W-1:0]  valid_bytes;
	} ctr_block_t;

	typedef struct packed {
		logic [WORD_W-1:0] out_high;
		logic [WORD_W-1:0] out_low;
		logic [CNT_W-1:0]  out_count;
	} ctr_result_t;

	logic clk;
	logic arst_n;

	aesctr_in_if  item_ch();
	aesctr_out_if result_ch();
	aesctr_cfg_if cfg_ch();

	aes128_ctr_crypt_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Local copy of the unit's programming and running state.
	logic [BLOCK_W-1:0] key_shadow;
	logic [BLOCK_W-1:0] nonce_shadow;
	logic [BLOCK_W-1:0] ctr_state;
	logic [BLOCK_W-1:0] round_keys [NUM_RK];
	logic [7:0]         sub_lut [256];

	ctr_block_t  blocks_to_send [$];
	ctr_result_t ctr_results_due [$];
	ctr_block_t  drv_block;
	ctr_result_t got_result;
	ctr_result_t want_result;

	int words_queued;
	int words_taken;
	int mismatches;
	int gap_left;
	int stall_left;
	int idle_pct;
	int stall_pct;
	logic quiet;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] gf_double(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[0])
				p = p ^ a;
			a = gf_double(a);
			b = b >> 1;
		end
		return p;
	endfunction

	// The S-box is built from the field inverse and the affine map, so it does
	// not share a table with the design.
	function automatic void build_sub_lut();
		logic [7:0] inv;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++)
				if (gf_mul(8'(x), 8'(y)) == 8'h01)
					inv = 8'(y);
			sub_lut[x] = inv ^ ((inv << 1) | (inv >> 7)) ^ ((inv << 2) | (inv >> 6))
				^ ((inv << 3) | (inv >> 5)) ^ ((inv << 4) | (inv >> 4)) ^ 8'h63;
		end
	endfunction

	function automatic void expand_round_keys(input logic [BLOCK_W-1:0] key);
		logic [31:0] w [44];
		logic [31:0] tmp;
		logic [7:0]  rc;
		rc = 8'h01;
		for (int i = 0; i < 4; i++)
			w[i] = key[127-32*i -: 32];
		for (int i = 4; i < 44; i++) begin
			tmp = w[i-1];
			if (i % 4 == 0) begin
				tmp = {sub_lut[tmp[23:16]] ^ rc, sub_lut[tmp[15:8]], sub_lut[tmp[7:0]],
					sub_lut[tmp[31:24]]};
				rc = gf_double(rc);
			end
			w[i] = w[i-4] ^ tmp;
		end
		for (int r = 0; r < NUM_RK; r++)
			round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
	endfunction

	// State bytes are column-major: byte r + 4c is row r of column c.
	function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127-8*(r+4*c) -: 8] = sub_lut[s[127-8*(r+4*((c+r)%4)) -: 8]];
		return t;
	endfunction

	function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] t;
		logic [7:0] a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127-32*c -: 8];
			a1 = s[119-32*c -: 8];
			a2 = s[111-32*c -: 8];
			a3 = s[103-32*c -: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[127-32*c -: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
			t[119-32*c -: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
			t[111-32*c -: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
			t[103-32*c -: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
		end
		return t;
	endfunction

	function automatic logic [BLOCK_W-1:0] aes_encrypt(input logic [BLOCK_W-1:0] s);
		s = s ^ round_keys[0];
		for (int r = 1; r < NUM_RND; r++)
			s = mix_columns(sub_shift(s)) ^ round_keys[r];
		return sub_shift(s) ^ round_keys[NUM_RND];
	endfunction

	// Expected result of one accepted word; advances the local counter.
	function automatic ctr_result_t ctr_crypt_word(input ctr_block_t b);
		ctr_result_t        res;
		logic [BLOCK_W-1:0] pad;
		logic [BLOCK_W-1:0] text;
		logic [CNT_W-1:0]   n;
		if (b.first_block) begin
			expand_round_keys(key_shadow);
			ctr_state = nonce_shadow;
		end
		n = (b.valid_bytes > 5'd16) ? 5'd16 : b.valid_bytes;
		pad = aes_encrypt(ctr_state);
		for (int i = 0; i < BYTES; i++)
			if (i >= n)
				pad[127-8*i -: 8] = 8'h00;
		text = {b.data_high, b.data_low} ^ pad;
		for (int i = 0; i < BYTES; i++)
			if (i >= n)
				text[127-8*i -: 8] = 8'h00;
		res.out_high = text[127:64];
		res.out_low = text[63:0];
		res.out_count = n;
		ctr_state = ctr_state + 1'b1;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// Input side: presents queued words, with idle bursts between them.
	always @(posedge clk) begin
		if (arst_n && (!item_ch.valid || item_ch.ready)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				item_ch.valid <= 1'b0;
			end else if (blocks_to_send.size() != 0) begin
				drv_block = blocks_to_send.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.first_block <= drv_block.first_block;
				item_ch.data_high <= drv_block.data_high;
				item_ch.data_low <= drv_block.data_low;
				item_ch.valid_bytes <= drv_block.valid_bytes;
				if (!quiet && $urandom_range(99) < idle_pct)
					gap_left <= $urandom_range(13, 1);
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Result side: ready drops in stall bursts of random length.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(99) < stall_pct) begin
			stall_left <= $urandom_range(12, 0);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					CFG_KEY_HIGH:   key_shadow[127:64] = cfg_ch.data;
					CFG_KEY_LOW:    key_shadow[63:0] = cfg_ch.data;
					CFG_NONCE_HIGH: nonce_shadow[127:64] = cfg_ch.data;
					CFG_NONCE_LOW:  nonce_shadow[63:0] = cfg_ch.data;
					default: ;
				endcase
			end
			if (result_ch.valid && result_ch.ready) begin
				got_result = {result_ch.out_high, result_ch.out_low, result_ch.out_count};
				if (ctr_results_due.size() == 0) begin
					report_mismatch($sformatf("result word %h with nothing expected", got_result));
				end else begin
					want_result = ctr_results_due.pop_front();
					if (got_result.out_high !== want_result.out_high)
						report_mismatch($sformatf("out_high %h, expected %h",
							got_result.out_high, want_result.out_high));
					if (got_result.out_low !== want_result.out_low)
						report_mismatch($sformatf("out_low %h, expected %h",
							got_result.out_low, want_result.out_low));
					if (got_result.out_count !== want_result.out_count)
						report_mismatch($sformatf("out_count %0d, expected %0d",
							got_result.out_count, want_result.out_count));
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				ctr_results_due.push_back(ctr_crypt_word({item_ch.first_block,
					item_ch.data_high, item_ch.data_low, item_ch.valid_bytes}));
				words_taken++;
			end
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic void queue_word(input logic first, input logic [WORD_W-1:0] hi,
		input logic [WORD_W-1:0] lo, input logic [CNT_W-1:0] n);
		blocks_to_send.push_back({first, hi, lo, n});
		words_queued++;
	endfunction

	// Must be called right after a rising edge.
	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic load_settings(input logic [BLOCK_W-1:0] key,
		input logic [BLOCK_W-1:0] nonce);
		write_reg(CFG_KEY_HIGH, key[127:64]);
		write_reg(CFG_KEY_LOW, key[63:0]);
		write_reg(CFG_NONCE_HIGH, nonce[127:64]);
		write_reg(CFG_NONCE_LOW, nonce[63:0]);
		cfg_ch.valid <= 1'b0;
	endtask

	// Waits until every queued word has gone in and every result has come out,
	// then lets the unit settle.
	task automatic drain();
		do @(posedge clk); while (words_queued != words_taken || ctr_results_due.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [BLOCK_W-1:0] pick_value(input logic near_wrap);
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return near_wrap ? {rand_word(), 64'hffff_ffff_ffff_ffff - $urandom_range(8)}
				: {rand_word(), rand_word()};
		endcase
	endfunction

	initial begin
		int len;
		int target;
		logic carry_on;
		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.first_block = 1'b0;
		item_ch.data_high = '0;
		item_ch.data_low = '0;
		item_ch.valid_bytes = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_KEY_HIGH;
		cfg_ch.data = '0;
		key_shadow = '0;
		nonce_shadow = '0;
		ctr_state = '0;
		words_queued = 0;
		words_taken = 0;
		mismatches = 0;
		gap_left = 0;
		stall_left = 0;
		idle_pct = 20;
		stall_pct = 20;
		quiet = 1'b0;
		build_sub_lut();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero key with a counter that wraps to zero after the first word, then
		// every length class including zero and oversized lengths.
		load_settings('0, '1);
		queue_word(1'b1, '0, '0, 5'd16);
		queue_word(1'b0, '1, '1, 5'd16);
		queue_word(1'b0, '1, '1, 5'd0);
		queue_word(1'b0, '1, '1, 5'd1);
		queue_word(1'b0, rand_word(), rand_word(), 5'd15);
		queue_word(1'b0, '1, '1, 5'd17);
		queue_word(1'b0, rand_word(), rand_word(), 5'd31);
		queue_word(1'b0, rand_word(), rand_word(), 5'd8);
		drain();

		// All-one key; the low counter word carries into the high word.
		load_settings('1, {64'h0123_4567_89ab_cdef, 64'hffff_ffff_ffff_fffe});
		queue_word(1'b1, rand_word(), rand_word(), 5'd16);
		for (int j = 0; j < 3; j++)
			queue_word(1'b0, rand_word(), rand_word(), 5'd16);
		queue_word(1'b1, rand_word(), rand_word(), 5'd16);
		queue_word(1'b0, rand_word(), rand_word(), 5'd5);
		drain();

		// Standard AES-128 test key and block; zero data gives the cipher text.
		load_settings(128'h0001_0203_0405_0607_0809_0a0b_0c0d_0e0f,
			128'h0011_2233_4455_6677_8899_aabb_ccdd_eeff);
		queue_word(1'b1, '0, '0, 5'd16);
		queue_word(1'b0, '1, '1, 5'd16);
		drain();

		// A key write takes effect only at the next first word of a message.
		write_reg(CFG_KEY_LOW, rand_word());
		cfg_ch.valid <= 1'b0;
		queue_word(1'b0, rand_word(), rand_word(), 5'd16);
		queue_word(1'b1, rand_word(), rand_word(), 5'd12);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			quiet = (ph == 5);
			idle_pct = (ph % 3 == 0) ? 0 : $urandom_range(40, 5);
			stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(40, 5);
			load_settings(pick_value(1'b0), pick_value(1'b1));
			carry_on = 1'($urandom_range(1));
			target = words_queued + ((ph == 5) ? 60 : 110);
			while (words_queued < target) begin
				if ($urandom_range(9) == 0) begin
					queue_word(1'($urandom_range(1)), rand_word(), rand_word(),
						5'($urandom_range(31)));
				end else begin
					len = $urandom_range(16, 1);
					for (int j = 0; j < len; j++)
						queue_word(j == 0 && !carry_on, rand_word(), rand_word(),
							(j == len - 1) ? 5'($urandom_range(16, 1)) : 5'd16);
					carry_on = 1'b0;
				end
			end
			drain();
		end

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/aesctr_pkg.sv
rtl/aesctr_in_if.sv
rtl/aesctr_out_if.sv
rtl/aesctr_cfg_if.sv
rtl/aesctr_ram.sv
rtl/aesctr_keyexp.sv
rtl/aesctr_round.sv
rtl/aes128_ctr_crypt_unit.sv
dv/tb_aes128_ctr_crypt_unit.sv
